>>> hdl/btnf_pkg.sv
package btnf_pkg;

  localparam int ADDR_W = 33;
  localparam int HEAP_BYTES_DEF = 32768;
  localparam logic [15:0] CHUNK_RESET = 16'd4096;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NULL      = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [14:0] request_bytes;
    logic [14:0] block_address;
  } in_t;

  typedef struct packed {
    logic [14:0] result_address;
    logic [1:0]  status;
  } out_t;

endpackage

>>> hdl/boundary_tag_next_fit_allocator.sv
// Boundary-tag heap allocator with next-fit search over a one-read, one-write word memory.
// A transaction is taken when start is high and busy is low; busy then stays high until the
// result, which appears on out_data for exactly one cycle with out_valid, and the receiver
// cannot stall it. Every memory read goes through the single read port, so the time of a
// transaction is set by the heap layout. A release of address 0 keeps busy low and gives
// its result in the next cycle. Otherwise busy stays high until the result strobe, which
// comes in the cycle in which busy falls. An allocate of 0 bytes returns a null status.
// Other allocates search from the rover in a first pass, visiting block headers, and split
// the block found when the rest is large enough; when the first pass finds nothing, a
// second pass searches from the heap start. Failing both, the heap grows, merging with the
// free neighbors, and an exhausted heap ends with an exhausted status. A release frees the
// block and merges it with its free neighbors. The first allocate, or the first release of
// a nonzero address, also lays out the heap and grows it by the chunk, unless the chunk
// rounds to nothing or does not fit.
module boundary_tag_next_fit_allocator #(
  parameter int HEAP_BYTES = btnf_pkg::HEAP_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  btnf_pkg::in_t    in_data,
  output logic             out_valid,
  output btnf_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);

  localparam int WORDS = HEAP_BYTES / 4;
  localparam int IW = $clog2(WORDS);
  localparam int BRK_W = $clog2(HEAP_BYTES) + 1;

  localparam logic [1:0] CTX_LAY   = 2'd0;
  localparam logic [1:0] CTX_ALLOC = 2'd1;
  localparam logic [1:0] CTX_FREE  = 2'd2;

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_LAY0    = 6'd1;
  localparam logic [5:0] S_LAY1    = 6'd2;
  localparam logic [5:0] S_LAY2    = 6'd3;
  localparam logic [5:0] S_LAY3    = 6'd4;
  localparam logic [5:0] S_CONT    = 6'd5;
  localparam logic [5:0] S_ALLOC   = 6'd6;
  localparam logic [5:0] S_P1_0    = 6'd7;
  localparam logic [5:0] S_P1_1    = 6'd8;
  localparam logic [5:0] S_P1_CHK  = 6'd9;
  localparam logic [5:0] S_P2_0    = 6'd10;
  localparam logic [5:0] S_P2_ADV  = 6'd11;
  localparam logic [5:0] S_P2_CHK  = 6'd12;
  localparam logic [5:0] S_GROWSEL = 6'd13;
  localparam logic [5:0] S_GROW0   = 6'd14;
  localparam logic [5:0] S_GROW1   = 6'd15;
  localparam logic [5:0] S_GROW2   = 6'd16;
  localparam logic [5:0] S_CV0     = 6'd17;
  localparam logic [5:0] S_CV1     = 6'd18;
  localparam logic [5:0] S_CV2     = 6'd19;
  localparam logic [5:0] S_CV3     = 6'd20;
  localparam logic [5:0] S_CV4     = 6'd21;
  localparam logic [5:0] S_CV5     = 6'd22;
  localparam logic [5:0] S_REL0    = 6'd23;
  localparam logic [5:0] S_REL1    = 6'd24;
  localparam logic [5:0] S_REL2    = 6'd25;
  localparam logic [5:0] S_MG0     = 6'd26;
  localparam logic [5:0] S_MG1     = 6'd27;
  localparam logic [5:0] S_MG2     = 6'd28;
  localparam logic [5:0] S_MG3     = 6'd29;
  localparam logic [5:0] S_MG4     = 6'd30;
  localparam logic [5:0] S_MG5     = 6'd31;
  localparam logic [5:0] S_MGA     = 6'd32;
  localparam logic [5:0] S_MGB0    = 6'd33;
  localparam logic [5:0] S_MGB1    = 6'd34;
  localparam logic [5:0] S_MGC0    = 6'd35;
  localparam logic [5:0] S_MGC1    = 6'd36;
  localparam logic [5:0] S_MGC2    = 6'd37;
  localparam logic [5:0] S_MGC3    = 6'd38;
  localparam logic [5:0] S_MGR0    = 6'd39;
  localparam logic [5:0] S_MGR1    = 6'd40;
  localparam logic [5:0] S_MGDONE  = 6'd41;

  function automatic logic [16:0] round_growth(input logic [15:0] b);
    return {1'b0, b[15:3], 3'b000} + (b[2] ? 17'd8 : 17'd0);
  endfunction

  logic [5:0]            state_r, state_nxt;
  btnf_pkg::addr_t       bp_r, bp_nxt;
  btnf_pkg::addr_t       p_r, p_nxt;
  btnf_pkg::addr_t       n_r, n_nxt;
  logic [31:0]           size_r, size_nxt;
  logic [31:0]           ph_r, ph_nxt;
  logic                  pa_r, pa_nxt;
  logic [16:0]           grow_r, grow_nxt;
  logic [BRK_W-1:0]      brk_r, brk_nxt;
  logic [14:0]           rover_r, rover_nxt;
  logic                  started_r, started_nxt;
  logic [15:0]           chunk_r;
  logic                  op_r, op_nxt;
  logic [14:0]           req_r, req_nxt;
  logic [14:0]           addr_r, addr_nxt;
  logic [1:0]            ctx_r, ctx_nxt;
  logic                  out_valid_r;
  btnf_pkg::out_t        out_r;

  logic                  fin;
  logic [14:0]           fin_res;
  logic [1:0]            fin_stat;

  logic                  ram_we, ram_re;
  btnf_pkg::addr_t       ram_wa, ram_ra;
  logic [31:0]           ram_wd, ram_rd;

  logic [31:0]           rsz;
  logic                  ral;
  logic [15:0]           need;
  logic [31:0]           need32;
  btnf_pkg::addr_t       needx, brkx, grx, relx, nx;
  logic [31:0]           rest;
  logic [16:0]           g_lay;
  logic [15:0]           gmax;

  btnf_ram #(.WORDS(WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa[IW+1:2]),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra[IW+1:2]),
    .rdata (ram_rd)
  );

  assign rsz = {ram_rd[31:3], 3'b000};
  assign ral = ram_rd[0];
  assign need = (req_r <= 15'd8) ? 16'd16 : (({1'b0, req_r} + 16'd15) & 16'hFFF8);
  assign need32 = 32'(need);
  assign needx = btnf_pkg::addr_t'(need);
  assign brkx = btnf_pkg::addr_t'(brk_r);
  assign grx = btnf_pkg::addr_t'(grow_r);
  assign relx = btnf_pkg::addr_t'(addr_r);
  assign rest = size_r - need32;
  assign g_lay = round_growth(chunk_r);
  assign gmax = (need > chunk_r) ? need : chunk_r;

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    state_nxt = state_r;
    bp_nxt = bp_r;
    p_nxt = p_r;
    n_nxt = n_r;
    size_nxt = size_r;
    ph_nxt = ph_r;
    pa_nxt = pa_r;
    grow_nxt = grow_r;
    brk_nxt = brk_r;
    rover_nxt = rover_r;
    started_nxt = started_r;
    op_nxt = op_r;
    req_nxt = req_r;
    addr_nxt = addr_r;
    ctx_nxt = ctx_r;
    fin = 1'b0;
    fin_res = '0;
    fin_stat = btnf_pkg::STAT_DONE;
    ram_we = 1'b0;
    ram_wa = '0;
    ram_wd = '0;
    ram_re = 1'b0;
    ram_ra = '0;
    nx = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_data.opcode;
          req_nxt = in_data.request_bytes;
          addr_nxt = in_data.block_address;
          if (in_data.opcode == btnf_pkg::OP_ALLOC) begin
            state_nxt = started_r ? S_ALLOC : S_LAY0;
          end else if (in_data.block_address == 15'd0) begin
            fin = 1'b1;
            fin_stat = btnf_pkg::STAT_NULL;
          end else begin
            state_nxt = started_r ? S_REL0 : S_LAY0;
          end
        end
      end
      S_LAY0: begin
        ram_we = 1'b1;
        ram_wa = btnf_pkg::addr_t'(0);
        ram_wd = 32'd0;
        state_nxt = S_LAY1;
      end
      S_LAY1: begin
        ram_we = 1'b1;
        ram_wa = btnf_pkg::addr_t'(4);
        ram_wd = 32'd9;
        state_nxt = S_LAY2;
      end
      S_LAY2: begin
        ram_we = 1'b1;
        ram_wa = btnf_pkg::addr_t'(8);
        ram_wd = 32'd9;
        state_nxt = S_LAY3;
      end
      S_LAY3: begin
        ram_we = 1'b1;
        ram_wa = btnf_pkg::addr_t'(12);
        ram_wd = 32'd1;
        brk_nxt = BRK_W'(16);
        rover_nxt = 15'd8;
        started_nxt = 1'b1;
        if (g_lay != 17'd0) begin
          grow_nxt = g_lay;
          ctx_nxt = CTX_LAY;
          state_nxt = S_GROW0;
        end else begin
          state_nxt = S_CONT;
        end
      end
      S_CONT: begin
        state_nxt = (op_r == btnf_pkg::OP_ALLOC) ? S_ALLOC : S_REL0;
      end
      S_ALLOC: begin
        if (req_r == 15'd0) begin
          fin = 1'b1;
          fin_stat = btnf_pkg::STAT_NULL;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_P1_0;
        end
      end
      S_P1_0: begin
        ram_re = 1'b1;
        ram_ra = btnf_pkg::addr_t'(rover_r) - btnf_pkg::addr_t'(4);
        state_nxt = S_P1_1;
      end
      S_P1_1: begin
        bp_nxt = btnf_pkg::addr_t'(rover_r) + btnf_pkg::addr_t'(rsz);
        ram_re = 1'b1;
        ram_ra = bp_nxt - btnf_pkg::addr_t'(4);
        state_nxt = S_P1_CHK;
      end
      S_P1_CHK: begin
        if (rsz == 32'd0 || bp_r > brkx) begin
          state_nxt = S_P2_0;
        end else if (!ral && rsz > need32) begin
          state_nxt = S_CV0;
        end else begin
          bp_nxt = bp_r + btnf_pkg::addr_t'(rsz);
          ram_re = 1'b1;
          ram_ra = bp_nxt - btnf_pkg::addr_t'(4);
        end
      end
      S_P2_0: begin
        bp_nxt = btnf_pkg::addr_t'(8);
        if (rover_r > 15'd8) begin
          ram_re = 1'b1;
          ram_ra = btnf_pkg::addr_t'(4);
          state_nxt = S_P2_ADV;
        end else begin
          state_nxt = S_GROWSEL;
        end
      end
      S_P2_ADV: begin
        nx = bp_r + btnf_pkg::addr_t'(rsz);
        if (nx == bp_r) begin
          state_nxt = S_GROWSEL;
        end else begin
          bp_nxt = nx;
          ram_re = 1'b1;
          ram_ra = nx - btnf_pkg::addr_t'(4);
          state_nxt = S_P2_CHK;
        end
      end
      S_P2_CHK: begin
        if (!ral && rsz >= need32) begin
          state_nxt = S_CV0;
        end else if (bp_r < btnf_pkg::addr_t'(rover_r)) begin
          state_nxt = S_P2_ADV;
        end else begin
          state_nxt = S_GROWSEL;
        end
      end
      S_GROWSEL: begin
        grow_nxt = round_growth(gmax);
        ctx_nxt = CTX_ALLOC;
        state_nxt = S_GROW0;
      end
      S_GROW0: begin
        if (brkx + grx > btnf_pkg::addr_t'(HEAP_BYTES)) begin
          if (ctx_r == CTX_ALLOC) begin
            fin = 1'b1;
            fin_stat = btnf_pkg::STAT_EXHAUSTED;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CONT;
          end
        end else begin
          bp_nxt = brkx;
          ram_we = 1'b1;
          ram_wa = brkx - btnf_pkg::addr_t'(4);
          ram_wd = 32'(grow_r);
          state_nxt = S_GROW1;
        end
      end
      S_GROW1: begin
        ram_we = 1'b1;
        ram_wa = bp_r + grx - btnf_pkg::addr_t'(8);
        ram_wd = 32'(grow_r);
        state_nxt = S_GROW2;
      end
      S_GROW2: begin
        ram_we = 1'b1;
        ram_wa = bp_r + grx - btnf_pkg::addr_t'(4);
        ram_wd = 32'd1;
        brk_nxt = brk_r + BRK_W'(grow_r);
        state_nxt = S_MG0;
      end
      S_CV0: begin
        ram_re = 1'b1;
        ram_ra = bp_r - btnf_pkg::addr_t'(4);
        state_nxt = S_CV1;
      end
      S_CV1: begin
        size_nxt = rsz;
        ram_we = 1'b1;
        ram_wa = bp_r - btnf_pkg::addr_t'(4);
        if (rsz - need32 >= 32'd16) begin
          ram_wd = need32 | 32'd1;
          state_nxt = S_CV2;
        end else begin
          ram_wd = rsz | 32'd1;
          state_nxt = S_CV5;
        end
      end
      S_CV2: begin
        ram_we = 1'b1;
        ram_wa = bp_r + needx - btnf_pkg::addr_t'(8);
        ram_wd = need32 | 32'd1;
        state_nxt = S_CV3;
      end
      S_CV3: begin
        ram_we = 1'b1;
        ram_wa = bp_r + needx - btnf_pkg::addr_t'(4);
        ram_wd = rest;
        state_nxt = S_CV4;
      end
      S_CV4: begin
        ram_we = 1'b1;
        ram_wa = bp_r + needx + btnf_pkg::addr_t'(rest) - btnf_pkg::addr_t'(8);
        ram_wd = rest;
        fin = 1'b1;
        fin_res = bp_r[14:0];
        state_nxt = S_IDLE;
      end
      S_CV5: begin
        ram_we = 1'b1;
        ram_wa = bp_r + btnf_pkg::addr_t'(size_r) - btnf_pkg::addr_t'(8);
        ram_wd = size_r | 32'd1;
        fin = 1'b1;
        fin_res = bp_r[14:0];
        state_nxt = S_IDLE;
      end
      S_REL0: begin
        ram_re = 1'b1;
        ram_ra = relx - btnf_pkg::addr_t'(4);
        state_nxt = S_REL1;
      end
      S_REL1: begin
        size_nxt = rsz;
        ram_we = 1'b1;
        ram_wa = relx - btnf_pkg::addr_t'(4);
        ram_wd = rsz;
        state_nxt = S_REL2;
      end
      S_REL2: begin
        ram_we = 1'b1;
        ram_wa = relx + btnf_pkg::addr_t'(size_r) - btnf_pkg::addr_t'(8);
        ram_wd = size_r;
        bp_nxt = relx;
        ctx_nxt = CTX_FREE;
        state_nxt = S_MG0;
      end
      S_MG0: begin
        ram_re = 1'b1;
        ram_ra = bp_r - btnf_pkg::addr_t'(8);
        state_nxt = S_MG1;
      end
      S_MG1: begin
        p_nxt = bp_r - btnf_pkg::addr_t'(rsz);
        ram_re = 1'b1;
        ram_ra = p_nxt - btnf_pkg::addr_t'(4);
        state_nxt = S_MG2;
      end
      S_MG2: begin
        ph_nxt = rsz;
        ram_re = 1'b1;
        ram_ra = p_r + btnf_pkg::addr_t'(rsz) - btnf_pkg::addr_t'(8);
        state_nxt = S_MG3;
      end
      S_MG3: begin
        pa_nxt = ral;
        ram_re = 1'b1;
        ram_ra = bp_r - btnf_pkg::addr_t'(4);
        state_nxt = S_MG4;
      end
      S_MG4: begin
        size_nxt = rsz;
        n_nxt = bp_r + btnf_pkg::addr_t'(rsz);
        ram_re = 1'b1;
        ram_ra = n_nxt - btnf_pkg::addr_t'(4);
        state_nxt = S_MG5;
      end
      S_MG5: begin
        priority if (pa_r && ral) begin
          state_nxt = S_MGDONE;
        end else if (pa_r) begin
          size_nxt = size_r + rsz;
          ram_we = 1'b1;
          ram_wa = bp_r - btnf_pkg::addr_t'(4);
          ram_wd = size_nxt;
          state_nxt = S_MGA;
        end else if (ral) begin
          size_nxt = size_r + ph_r;
          ram_we = 1'b1;
          ram_wa = bp_r + btnf_pkg::addr_t'(size_r) - btnf_pkg::addr_t'(8);
          ram_wd = size_nxt;
          state_nxt = S_MGB0;
        end else begin
          ram_re = 1'b1;
          ram_ra = n_r + btnf_pkg::addr_t'(rsz) - btnf_pkg::addr_t'(8);
          state_nxt = S_MGC0;
        end
      end
      S_MGA: begin
        ram_we = 1'b1;
        ram_wa = bp_r + btnf_pkg::addr_t'(size_r) - btnf_pkg::addr_t'(8);
        ram_wd = size_r;
        state_nxt = S_MGDONE;
      end
      S_MGB0: begin
        ram_re = 1'b1;
        ram_ra = bp_r - btnf_pkg::addr_t'(8);
        state_nxt = S_MGB1;
      end
      S_MGB1: begin
        ram_we = 1'b1;
        ram_wa = bp_r - btnf_pkg::addr_t'(rsz) - btnf_pkg::addr_t'(4);
        ram_wd = size_r;
        state_nxt = S_MGR0;
      end
      S_MGC0: begin
        size_nxt = size_r + ph_r + rsz;
        ram_we = 1'b1;
        ram_wa = p_r - btnf_pkg::addr_t'(4);
        ram_wd = size_nxt;
        state_nxt = S_MGC1;
      end
      S_MGC1: begin
        ram_re = 1'b1;
        ram_ra = bp_r - btnf_pkg::addr_t'(4);
        state_nxt = S_MGC2;
      end
      S_MGC2: begin
        n_nxt = bp_r + btnf_pkg::addr_t'(rsz);
        ram_re = 1'b1;
        ram_ra = n_nxt - btnf_pkg::addr_t'(4);
        state_nxt = S_MGC3;
      end
      S_MGC3: begin
        ram_we = 1'b1;
        ram_wa = n_r + btnf_pkg::addr_t'(rsz) - btnf_pkg::addr_t'(8);
        ram_wd = size_r;
        state_nxt = S_MGR0;
      end
      S_MGR0: begin
        ram_re = 1'b1;
        ram_ra = bp_r - btnf_pkg::addr_t'(8);
        state_nxt = S_MGR1;
      end
      S_MGR1: begin
        bp_nxt = bp_r - btnf_pkg::addr_t'(rsz);
        state_nxt = S_MGDONE;
      end
      S_MGDONE: begin
        rover_nxt = bp_r[14:0];
        priority case (ctx_r)
          CTX_FREE: begin
            fin = 1'b1;
            state_nxt = S_IDLE;
          end
          CTX_LAY: begin
            state_nxt = S_CONT;
          end
          default: begin
            state_nxt = S_CV0;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      brk_r <= '0;
      rover_r <= '0;
      started_r <= 1'b0;
      chunk_r <= btnf_pkg::CHUNK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      brk_r <= brk_nxt;
      rover_r <= rover_nxt;
      started_r <= started_nxt;
      if (cfg_valid && cfg_ready) begin
        chunk_r <= cfg_data;
      end
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    bp_r <= bp_nxt;
    p_r <= p_nxt;
    n_r <= n_nxt;
    size_r <= size_nxt;
    ph_r <= ph_nxt;
    pa_r <= pa_nxt;
    grow_r <= grow_nxt;
    op_r <= op_nxt;
    req_r <= req_nxt;
    addr_r <= addr_nxt;
    ctx_r <= ctx_nxt;
    if (fin) begin
      out_r.result_address <= fin_res;
      out_r.status <= fin_stat;
    end
  end

endmodule

>>> hdl/btnf_ram.sv
module btnf_ram #(
  parameter int WORDS = btnf_pkg::HEAP_BYTES_DEF / 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [31:0]              rdata
);

  logic [31:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  btnf_pkg::in_t in_data = '0;
  logic out_valid;
  btnf_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  boundary_tag_next_fit_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] heap_model [0:8191];
  logic [31:0] brk_model;
  logic [31:0] rover_model;
  logic heap_laid_out;
  logic [15:0] chunk_model;

  btnf_pkg::in_t pending_requests[$];
  btnf_pkg::out_t awaited_results[$];
  logic [14:0] live_blocks[$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  function automatic logic [31:0] word_at(longint unsigned a);
    return heap_model[a[14:2]];
  endfunction

  function automatic void put_word(longint unsigned a, logic [31:0] v);
    heap_model[a[14:2]] = v;
  endfunction

  function automatic logic [31:0] size_at(longint unsigned a);
    return word_at(a) & ~32'h7;
  endfunction

  function automatic logic used_at(longint unsigned a);
    logic [31:0] w;
    w = word_at(a);
    return w[0];
  endfunction

  function automatic longint unsigned next_blk(longint unsigned bp);
    return bp + size_at(bp - 4);
  endfunction

  function automatic longint unsigned prev_blk(longint unsigned bp);
    return bp - size_at(bp - 8);
  endfunction

  function automatic longint unsigned foot(longint unsigned bp);
    return bp + size_at(bp - 4) - 8;
  endfunction

  function automatic longint unsigned coalesce(longint unsigned bp);
    logic pa, na;
    logic [31:0] sz;
    pa = used_at(foot(prev_blk(bp)));
    na = used_at(next_blk(bp) - 4);
    sz = size_at(bp - 4);
    if (pa && !na) begin
      sz = sz + size_at(next_blk(bp) - 4);
      put_word(bp - 4, sz);
      put_word(foot(bp), sz);
    end else if (!pa && na) begin
      sz = sz + size_at(prev_blk(bp) - 4);
      put_word(foot(bp), sz);
      put_word(prev_blk(bp) - 4, sz);
      bp = prev_blk(bp);
    end else if (!pa && !na) begin
      sz = sz + size_at(prev_blk(bp) - 4) + size_at(foot(next_blk(bp)));
      put_word(prev_blk(bp) - 4, sz);
      put_word(foot(next_blk(bp)), sz);
      bp = prev_blk(bp);
    end
    rover_model = 32'(bp & 64'h7FFF);
    return bp;
  endfunction

  function automatic bit heap_grow(logic [31:0] bytes, output longint unsigned bp);
    bp = brk_model;
    if (longint'(brk_model) + bytes > 32768) return 1'b0;
    put_word(bp - 4, bytes);
    put_word(bp + bytes - 8, bytes);
    put_word(bp + bytes - 4, 32'h1);
    brk_model = brk_model + bytes;
    bp = coalesce(bp);
    return 1'b1;
  endfunction

  function automatic logic [31:0] growth_bytes(logic [31:0] bytes);
    logic [31:0] w;
    w = bytes / 4;
    if (w[0]) w = w + 1;
    return w * 4;
  endfunction

  function automatic void init_heap();
    longint unsigned unused;
    logic [31:0] g;
    put_word(0, 0);
    put_word(4, 32'h9);
    put_word(8, 32'h9);
    put_word(12, 32'h1);
    brk_model = 16;
    rover_model = 8;
    heap_laid_out = 1'b1;
    g = growth_bytes(32'(chunk_model));
    if (g != 0) void'(heap_grow(g, unused));
  endfunction

  function automatic bit fit_search(logic [31:0] need, output longint unsigned hit);
    longint unsigned bp, n;
    for (bp = next_blk(rover_model); size_at(bp - 4) != 0 && bp <= brk_model;
         bp = next_blk(bp)) begin
      if (!used_at(bp - 4) && size_at(bp - 4) > need) begin
        hit = bp;
        return 1'b1;
      end
    end
    bp = 8;
    while (bp < rover_model) begin
      n = next_blk(bp);
      if (n == bp) break;
      bp = n;
      if (!used_at(bp - 4) && size_at(bp - 4) >= need) begin
        hit = bp;
        return 1'b1;
      end
    end
    hit = 0;
    return 1'b0;
  endfunction

  function automatic void place_block(longint unsigned bp, logic [31:0] need);
    logic [31:0] csize, rest;
    csize = size_at(bp - 4);
    rest = csize - need;
    if (rest >= 16) begin
      put_word(bp - 4, need | 32'h1);
      put_word(foot(bp), need | 32'h1);
      bp = next_blk(bp);
      put_word(bp - 4, rest);
      put_word(foot(bp), rest);
    end else begin
      put_word(bp - 4, csize | 32'h1);
      put_word(foot(bp), csize | 32'h1);
    end
  endfunction

  function automatic btnf_pkg::out_t predict_allocator(btnf_pkg::in_t req);
    btnf_pkg::out_t r;
    logic [31:0] need, sz;
    longint unsigned bp;
    r = '0;
    r.status = btnf_pkg::STAT_DONE;
    if (req.opcode == btnf_pkg::OP_ALLOC) begin
      if (!heap_laid_out) init_heap();
      if (req.request_bytes == 0) begin
        r.status = btnf_pkg::STAT_NULL;
        return r;
      end
      need = (req.request_bytes <= 8) ? 32'd16 : 8 * ((req.request_bytes + 15) / 8);
      if (!fit_search(need, bp)) begin
        if (!heap_grow(growth_bytes(need > chunk_model ? need : 32'(chunk_model)), bp))
        begin
          r.status = btnf_pkg::STAT_EXHAUSTED;
          return r;
        end
      end
      place_block(bp, need);
      r.result_address = bp[14:0];
      live_blocks.push_back(bp[14:0]);
    end else begin
      if (req.block_address == 0) begin
        r.status = btnf_pkg::STAT_NULL;
        return r;
      end
      if (!heap_laid_out) init_heap();
      bp = req.block_address;
      sz = size_at(bp - 4);
      put_word(bp - 4, sz);
      put_word(foot(bp), sz);
      void'(coalesce(bp));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back(predict_allocator(in_data));
      end
      if (!start || !busy) begin
        if (pending_requests.size() > 0 && (no_idle || $urandom_range(99) >= 34)) begin
          in_data <= pending_requests.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    btnf_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $realtime);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.result_address !== want.result_address)
          report_mismatch("result_address", int'(out_data.result_address),
                          int'(want.result_address));
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_requests.size() > 0 || awaited_results.size() > 0 || start)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_chunk(logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    chunk_model = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_request(logic op, logic [14:0] bytes, logic [14:0] addr);
    btnf_pkg::in_t t;
    while (pending_requests.size() > 0) @(negedge clk);
    t.opcode = op;
    t.request_bytes = bytes;
    t.block_address = addr;
    pending_requests.push_back(t);
  endtask

  task automatic release_live(int idx);
    logic [14:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    queue_request(btnf_pkg::OP_FREE, 15'($urandom), a);
  endtask

  task automatic random_request();
    int pick, sel;
    logic [14:0] bytes;
    pick = $urandom_range(99);
    if (pick < 40 && live_blocks.size() > 0) begin
      release_live(int'($urandom_range(live_blocks.size() - 1)));
    end else if (pick < 45) begin
      queue_request(btnf_pkg::OP_FREE, 15'($urandom), 15'd0);
    end else begin
      sel = $urandom_range(99);
      if (sel < 80) bytes = 15'($urandom_range(64, 1));
      else if (sel < 90) bytes = 15'($urandom_range(1024, 65));
      else if (sel < 95) bytes = 15'd0;
      else bytes = 15'($urandom);
      queue_request(btnf_pkg::OP_ALLOC, bytes, 15'($urandom));
    end
  endtask

  initial begin
    logic [15:0] chunk_plan [8];
    heap_laid_out = 1'b0;
    brk_model = 0;
    rover_model = 0;
    chunk_model = btnf_pkg::CHUNK_RESET;
    foreach (heap_model[i]) heap_model[i] = '0;
    chunk_plan = '{16'd8, 16'd4096, 16'd32768, 16'd24, 16'd4096,
                   16'(8 * $urandom_range(4096, 1)), 16'd16384, 16'd8};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_chunk(chunk_plan[0]);
    queue_request(btnf_pkg::OP_ALLOC, 15'd0, 15'h7FFF);
    queue_request(btnf_pkg::OP_FREE, 15'h7FFF, 15'd0);
    queue_request(btnf_pkg::OP_ALLOC, 15'd1, 15'd0);
    queue_request(btnf_pkg::OP_ALLOC, 15'd8, 15'd0);
    queue_request(btnf_pkg::OP_ALLOC, 15'd9, 15'd0);
    queue_request(btnf_pkg::OP_ALLOC, 15'd16, 15'd0);
    queue_request(btnf_pkg::OP_ALLOC, 15'd17, 15'd0);
    queue_request(btnf_pkg::OP_ALLOC, 15'd24, 15'd0);
    queue_request(btnf_pkg::OP_ALLOC, 15'h7FFF, 15'd0);
    wait_idle();
    release_live(1);
    release_live(2);
    release_live(1);
    wait_idle();
    release_live(0);
    queue_request(btnf_pkg::OP_ALLOC, 15'd40, 15'd0);
    queue_request(btnf_pkg::OP_ALLOC, 15'd4000, 15'd0);
    wait_idle();
    release_live(live_blocks.size() - 1);
    queue_request(btnf_pkg::OP_ALLOC, 15'd100, 15'd0);

    foreach (chunk_plan[p]) begin
      wait_idle();
      if (p > 0) write_chunk(chunk_plan[p]);
      no_idle = (p == 1);
      repeat (100) random_request();
    end
    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
